/* rtl/dsu_pkg.sv */
// ----------------------------------------------------------------------------
// Disjoint-set engine package
// Shared types, sizes and codes for the union-find engine with union by rank
// and full path compression.
// ----------------------------------------------------------------------------
package dsu_pkg;

	// The vertex count must be a power of two, so that reducing an index
	// modulo the count is a plain truncation.
	localparam int NUM_VERTICES = 1024;
	localparam int VTX_W        = $clog2(NUM_VERTICES);
	localparam int IN_VTX_W     = 10;
	localparam int ROOT_W       = 10;
	localparam int RANK_W       = 4;
	localparam int OP_W         = 2;

	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	localparam logic [OP_W-1:0] OP_FIND      = 2'd0;
	localparam logic [OP_W-1:0] OP_CONNECTED = 2'd1;
	localparam logic [OP_W-1:0] OP_MERGE     = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

	typedef logic [VTX_W-1:0] vtx_t;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [IN_VTX_W-1:0] first_vertex;
		logic [IN_VTX_W-1:0] second_vertex;
	} req_t;

	typedef struct packed {
		logic [ROOT_W-1:0] root_vertex;
		logic              answer_flag;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_COMP_RD,
		ST_COMP_CHK,
		ST_JUDGE,
		ST_RANK_B,
		ST_LINK,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_en;
		logic load;
		logic walk_adv;
		logic walk_root;
		logic comp_adv;
		logic end_a;
		logic end_b;
		logic res_pair;
		logic res_zero;
		logic cap_rank_a;
		logic rank_sel_b;
		logic link;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            phase_b;
		logic            self_loop;
		logic            roots_equal;
		logic            clear_last;
	} dp_status_t;

	// Index reduction modulo the (power of two) vertex count.
	function automatic vtx_t clamp_vertex(input logic [IN_VTX_W-1:0] v);
		return VTX_W'(v);
	endfunction

	function automatic logic [ROOT_W-1:0] to_root(input vtx_t v);
		return ROOT_W'(v);
	endfunction

endpackage

/* rtl/disjoint_set_union_find.sv */
// ----------------------------------------------------------------------------
// Disjoint-set union-find engine
// Union by rank with full path compression over a fixed vertex set.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 1024 vertices (one vertex
// per cycle) with busy high; then it takes a request whenever start is high and
// busy is low. Exactly one result follows each request, on result for one
// cycle with done high, and it cannot be held off. The parent table is one
// memory with a registered read, so each hop of a walk takes a read state and
// a check state, and every find walks its path twice (once to the root, once
// to compress). Connected and union walk from both vertices; a union that
// links two sets then looks up the ranks and links the roots. The unused
// opcode goes straight to a zero result. A new request can be taken the cycle
// after done.
module disjoint_set_union_find (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dsu_pkg::req_t  request,
	output logic           done,
	output dsu_pkg::rsp_t  result
);
	import dsu_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dsu_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

endmodule

/* rtl/dsu_datapath.sv */
// ----------------------------------------------------------------------------
// Disjoint-set engine datapath
// Parent and rank memories, walk registers, root registers and the result
// register. Every step is ordered by the controller.
// ----------------------------------------------------------------------------
module dsu_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  dsu_pkg::req_t       request,
	input  dsu_pkg::dp_cmd_t    cmd,
	output dsu_pkg::dp_status_t status,
	output dsu_pkg::rsp_t       result
);
	import dsu_pkg::*;

	logic [VTX_W-1:0]  parent_mem [NUM_VERTICES];
	logic [RANK_W-1:0] rank_mem   [NUM_VERTICES];

	logic [OP_W-1:0]   op_q;
	vtx_t              node_q;
	vtx_t              start_q;
	vtx_t              vb_q;
	vtx_t              root_q;
	vtx_t              ra_q;
	vtx_t              rb_q;
	vtx_t              clr_q;
	logic              phase_b_q;
	logic [RANK_W-1:0] rank_a_q;
	vtx_t              par_rd_q;
	logic [RANK_W-1:0] rank_rd_q;
	rsp_t              res_q;

	logic              pw_en;
	vtx_t              pw_addr;
	vtx_t              pw_data;
	logic              rw_en;
	vtx_t              rw_addr;
	logic [RANK_W-1:0] rw_data;
	vtx_t              rank_addr;
	logic              a_higher;
	logic              b_higher;

	assign a_higher  = rank_a_q > rank_rd_q;
	assign b_higher  = rank_rd_q > rank_a_q;
	assign rank_addr = cmd.rank_sel_b ? rb_q : ra_q;

	// Write port selection: clearing pass, path compression or linking.
	always_comb begin
		pw_en   = 1'b0;
		pw_addr = node_q;
		pw_data = root_q;
		rw_en   = 1'b0;
		rw_addr = ra_q;
		rw_data = '0;
		if (cmd.clear_en) begin
			pw_en   = 1'b1;
			pw_addr = clr_q;
			pw_data = clr_q;
			rw_en   = 1'b1;
			rw_addr = clr_q;
		end else if (cmd.comp_adv) begin
			pw_en = 1'b1;
		end else if (cmd.link) begin
			pw_en = 1'b1;
			if (b_higher) begin
				pw_addr = ra_q;
				pw_data = rb_q;
			end else begin
				pw_addr = rb_q;
				pw_data = ra_q;
			end
			// Equal ranks: the first root grows by one, saturating.
			if (!a_higher && !b_higher && rank_a_q != RANK_MAX) begin
				rw_en   = 1'b1;
				rw_data = rank_a_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pw_en) begin
			parent_mem[pw_addr] <= pw_data;
		end
		par_rd_q <= parent_mem[node_q];
	end

	always_ff @(posedge clk) begin
		if (rw_en) begin
			rank_mem[rw_addr] <= rw_data;
		end
		rank_rd_q <= rank_mem[rank_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			phase_b_q <= 1'b0;
		end else begin
			if (cmd.clear_en) begin
				clr_q <= clr_q + VTX_W'(1);
			end
			if (cmd.load) begin
				phase_b_q <= 1'b0;
			end else if (cmd.end_a) begin
				phase_b_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= request.opcode;
			node_q  <= clamp_vertex(request.first_vertex);
			start_q <= clamp_vertex(request.first_vertex);
			vb_q    <= clamp_vertex(request.second_vertex);
		end
		if (cmd.walk_adv || cmd.comp_adv) begin
			node_q <= par_rd_q;
		end
		if (cmd.walk_root) begin
			root_q <= node_q;
			node_q <= start_q;
		end
		if (cmd.end_a) begin
			ra_q    <= root_q;
			node_q  <= vb_q;
			start_q <= vb_q;
			res_q   <= '{root_vertex: to_root(root_q), answer_flag: 1'b0};
		end
		if (cmd.end_b) begin
			rb_q <= root_q;
		end
		if (cmd.res_pair) begin
			res_q.answer_flag <= (ra_q == rb_q);
		end
		if (cmd.cap_rank_a) begin
			rank_a_q <= rank_rd_q;
		end
		if (cmd.link) begin
			res_q <= '{root_vertex: to_root(b_higher ? rb_q : ra_q), answer_flag: 1'b1};
		end
		if (cmd.res_zero) begin
			res_q <= '0;
		end
	end

	assign status.op          = op_q;
	assign status.phase_b     = phase_b_q;
	assign status.self_loop   = (par_rd_q == node_q);
	assign status.roots_equal = (ra_q == rb_q);
	assign status.clear_last  = (clr_q == VTX_W'(NUM_VERTICES - 1));
	assign result             = res_q;

endmodule

/* rtl/dsu_ctrl.sv */
// ----------------------------------------------------------------------------
// Disjoint-set engine controller
// State machine that sequences the clearing pass, the two walks of each find,
// the rank lookups and the link of a union.
// ----------------------------------------------------------------------------
module dsu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dsu_pkg::dp_status_t status,
	output dsu_pkg::dp_cmd_t    cmd,
	output logic                busy,
	output logic                done
);
	import dsu_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				state_d = (status.op == OP_NONE) ? ST_DONE : ST_WALK_RD;
			end
			ST_WALK_RD:  state_d = ST_WALK_CHK;
			ST_WALK_CHK: begin
				state_d = status.self_loop ? ST_COMP_RD : ST_WALK_RD;
			end
			ST_COMP_RD:  state_d = ST_COMP_CHK;
			ST_COMP_CHK: begin
				if (!status.self_loop) begin
					state_d = ST_COMP_RD;
				end else if (status.phase_b) begin
					state_d = ST_JUDGE;
				end else if (status.op == OP_FIND) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_WALK_RD;
				end
			end
			ST_JUDGE: begin
				if (status.op == OP_MERGE && !status.roots_equal) begin
					state_d = ST_RANK_B;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RANK_B: state_d = ST_LINK;
			ST_LINK:   state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clear_en = 1'b1;
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DISPATCH: cmd.res_zero = (status.op == OP_NONE);
			ST_WALK_RD:  ;
			ST_WALK_CHK: begin
				cmd.walk_root = status.self_loop;
				cmd.walk_adv  = !status.self_loop;
			end
			ST_COMP_RD:  ;
			ST_COMP_CHK: begin
				cmd.comp_adv = !status.self_loop;
				cmd.end_a    = status.self_loop && !status.phase_b;
				cmd.end_b    = status.self_loop && status.phase_b;
			end
			ST_JUDGE: cmd.res_pair = (status.op == OP_CONNECTED);
			ST_RANK_B: begin
				cmd.cap_rank_a = 1'b1;
				cmd.rank_sel_b = 1'b1;
			end
			ST_LINK: cmd.link = 1'b1;
			ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

endmodule

/* rtl/dsu_checker.sv */
// ----------------------------------------------------------------------------
// Disjoint-set engine port checker
// Watches the request and result handshake of the top level over time.
// ----------------------------------------------------------------------------
module dsu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input dsu_pkg::req_t request,
	input dsu_pkg::rsp_t result
);
	import dsu_pkg::*;

	// An accepted request keeps the block busy until its result.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted request");

	// The result strobe lasts one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// The block is free for the next request right after a result.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy still high after a result");

	// No result appears while the block is waiting for a request.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !done)
		else $error("result strobe while idle");

	// A request with the unused opcode must give an empty result.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.opcode == OP_NONE |=> ##1 done && result == '0)
		else $error("unused opcode gave a nonzero result");

endmodule

bind disjoint_set_union_find dsu_checker u_dsu_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.request (request),
	.result  (result)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Union-find engine testbench
// Sends find, connected, union and unused-opcode requests through the
// start/busy handshake. A local forest model with union by rank and path
// compression predicts each result, and each done strobe is checked against
// the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dsu_pkg::*;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic done;
	rsp_t result;

	// Local copy of the forest, updated as each request is accepted.
	vtx_t             parent_of [NUM_VERTICES];
	logic [RANK_W-1:0] rank_of   [NUM_VERTICES];

	rsp_t pending_results [$];
	bit   mismatch_seen = 1'b0;
	bit   idle_on = 1'b1;
	int   hot_base = 0;
	int   hot_span = 32;

	disjoint_set_union_find i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#1_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Walks to the root, then points every vertex on the path at it.
	function automatic vtx_t find_and_compress(input vtx_t v);
		vtx_t node;
		vtx_t root;
		vtx_t up;
		int   hops;
		node = v;
		hops = 0;
		while (parent_of[node] != node && hops < NUM_VERTICES) begin
			node = parent_of[node];
			hops++;
		end
		root = node;
		node = v;
		hops = 0;
		while (parent_of[node] != node && hops < NUM_VERTICES) begin
			up = parent_of[node];
			parent_of[node] = root;
			node = up;
			hops++;
		end
		return root;
	endfunction

	function automatic rsp_t predict_dsu_result(input req_t r);
		vtx_t va;
		vtx_t vb;
		vtx_t ra;
		vtx_t rb;
		vtx_t head;
		rsp_t rsp;
		va = vtx_t'(r.first_vertex % NUM_VERTICES);
		vb = vtx_t'(r.second_vertex % NUM_VERTICES);
		rsp = '0;
		case (r.opcode)
			OP_FIND: begin
				rsp.root_vertex = ROOT_W'(find_and_compress(va));
			end
			OP_CONNECTED: begin
				ra = find_and_compress(va);
				rb = find_and_compress(vb);
				rsp.root_vertex = ROOT_W'(ra);
				rsp.answer_flag = (ra == rb);
			end
			OP_MERGE: begin
				ra = find_and_compress(va);
				rb = find_and_compress(vb);
				if (ra == rb) begin
					head = ra;
				end else begin
					rsp.answer_flag = 1'b1;
					if (rank_of[ra] > rank_of[rb]) begin
						parent_of[rb] = ra;
						head = ra;
					end else if (rank_of[rb] > rank_of[ra]) begin
						parent_of[ra] = rb;
						head = rb;
					end else begin
						// Equal ranks: the first root takes the second.
						parent_of[rb] = ra;
						if (rank_of[ra] < RANK_MAX)
							rank_of[ra] = rank_of[ra] + 1'b1;
						head = ra;
					end
				end
				rsp.root_vertex = ROOT_W'(head);
			end
			default: ;
		endcase
		return rsp;
	endfunction

	function automatic req_t make_request(input logic [OP_W-1:0] op,
		input int a, input int b);
		req_t r;
		r.opcode = op;
		r.first_vertex = IN_VTX_W'(a);
		r.second_vertex = IN_VTX_W'(b);
		return r;
	endfunction

	function automatic int pick_hot();
		return (hot_base + $urandom_range(0, hot_span - 1)) % (1 << IN_VTX_W);
	endfunction

	function automatic req_t make_random_request();
		int   w;
		req_t r;
		if ($urandom_range(0, 99) < 15) begin
			// Noise: any opcode, any vertex.
			r.opcode = OP_W'($urandom());
			r.first_vertex = IN_VTX_W'($urandom());
			r.second_vertex = IN_VTX_W'($urandom());
		end else begin
			w = $urandom_range(0, 99);
			if (w < 30)
				r.opcode = OP_FIND;
			else if (w < 60)
				r.opcode = OP_CONNECTED;
			else if (w < 95)
				r.opcode = OP_MERGE;
			else
				r.opcode = OP_NONE;
			r.first_vertex = IN_VTX_W'(pick_hot());
			r.second_vertex = IN_VTX_W'(pick_hot());
		end
		return r;
	endfunction

	// Called just after a rising edge; returns at the edge that accepted the
	// request, with start still high.
	task automatic issue_request(input req_t r);
		request <= r;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(predict_dsu_result(r));
	endtask

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: root_vertex %0d answer_flag %0d",
					result.root_vertex, result.answer_flag);
				mismatch_seen = 1'b1;
			end else begin
				if (result.root_vertex !== pending_results[0].root_vertex) begin
					$error("root_vertex: expected %0d, actual %0d",
						pending_results[0].root_vertex, result.root_vertex);
					mismatch_seen = 1'b1;
				end
				if (result.answer_flag !== pending_results[0].answer_flag) begin
					$error("answer_flag: expected %0d, actual %0d",
						pending_results[0].answer_flag, result.answer_flag);
					mismatch_seen = 1'b1;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	task automatic test_directed();
		issue_request(make_request(OP_FIND, 0, 0));
		issue_request(make_request(OP_FIND, 1023, 1023));
		issue_request(make_request(OP_CONNECTED, 0, 1023));
		issue_request(make_request(OP_MERGE, 0, 1023));
		sender_gap();
		issue_request(make_request(OP_MERGE, 1023, 0));
		issue_request(make_request(OP_CONNECTED, 1023, 0));
		issue_request(make_request(OP_MERGE, 5, 5));
		issue_request(make_request(OP_NONE, 1023, 1023));
		issue_request(make_request(OP_NONE, 0, 0));
		sender_gap();
		// Build two rank-one trees, then merge them on equal ranks.
		issue_request(make_request(OP_MERGE, 1, 2));
		issue_request(make_request(OP_MERGE, 3, 1));
		issue_request(make_request(OP_MERGE, 2, 6));
		issue_request(make_request(OP_MERGE, 7, 10'h2AA));
		issue_request(make_request(OP_MERGE, 10'h155, 7));
		issue_request(make_request(OP_MERGE, 1, 7));
		sender_gap();
		issue_request(make_request(OP_FIND, 10'h2AA, 0));
		issue_request(make_request(OP_CONNECTED, 10'h155, 3));
		issue_request(make_request(OP_CONNECTED, 10'h2AA, 1023));
		issue_request(make_request(OP_MERGE, 1023, 10'h2AA));
		issue_request(make_request(OP_FIND, 0, 1023));
		issue_request(make_request(OP_NONE, 10'h2AA, 10'h155));
		issue_request(make_request(OP_FIND, 1023, 0));
		drain_results();
	endtask

	// A binomial tree on a fresh block gives the longest paths rank allows.
	task automatic test_deep_paths();
		localparam int BASE = 128;
		localparam int SIZE = 128;
		int step;
		int i;
		for (step = 1; step < SIZE; step = step * 2) begin
			for (i = 0; i < SIZE; i = i + 2 * step) begin
				issue_request(make_request(OP_MERGE, BASE + i, BASE + i + step));
				sender_gap();
			end
		end
		drain_results();
		issue_request(make_request(OP_FIND, BASE + SIZE - 1, 0));
		for (i = 0; i < 20; i++) begin
			issue_request(make_request(OP_FIND, BASE + $urandom_range(0, SIZE - 1), 0));
			sender_gap();
		end
		for (i = 0; i < 10; i++) begin
			issue_request(make_request(OP_CONNECTED, BASE + $urandom_range(0, SIZE - 1),
				BASE + $urandom_range(0, SIZE - 1)));
			sender_gap();
		end
		for (i = 0; i < 4; i++) begin
			issue_request(make_request(OP_MERGE, BASE + $urandom_range(0, SIZE - 1),
				$urandom_range(0, 1023)));
			sender_gap();
		end
	endtask

	task automatic test_random_forest();
		int chunk;
		int i;
		for (chunk = 0; chunk < 14; chunk++) begin
			hot_base = $urandom_range(0, 1023);
			case ($urandom_range(0, 2))
				0: hot_span = 8;
				1: hot_span = 32;
				default: hot_span = 128;
			endcase
			idle_on = $urandom_range(0, 1);
			for (i = 0; i < 50; i++) begin
				issue_request(make_random_request());
				sender_gap();
			end
			if (chunk == 7)
				drain_results();
		end
	endtask

	task automatic test_back_to_back();
		int i;
		idle_on = 1'b0;
		hot_base = $urandom_range(0, 1023);
		hot_span = 48;
		for (i = 0; i < 150; i++)
			issue_request(make_random_request());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_deep_paths();
		test_random_forest();
		test_back_to_back();
		drain_results();
		repeat (200) @(posedge clk);
		if (!mismatch_seen && pending_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		for (int v = 0; v < NUM_VERTICES; v++) begin
			parent_of[v] = vtx_t'(v);
			rank_of[v] = '0;
		end
	end

endmodule
